>>> design/lge_pkg.sv
// lge_pkg: shared widths, request codes and default grid size for the
// life generation engine. Depends on nothing; used by the top level and its checker.
package lge_pkg;

   localparam int ROWS_DEF = 64;
   localparam int COLS_DEF = 128;

   localparam int KIND_W = 2;
   localparam int ROW_W  = 6;
   localparam int COL_W  = 7;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type REQ_WRITE   = 2'd0;
   localparam kind_type REQ_READ    = 2'd1;
   localparam kind_type REQ_ADVANCE = 2'd2;
   localparam kind_type REQ_NOP     = 2'd3;

endpackage

>>> design/lge_ram.sv
// lge_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// Standalone; no package needed.
module lge_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/life_generation_engine.sv
// life_generation_engine: B3/S23 life grid held one row per RAM word.
// Depends on lge_pkg and lge_ram.
//
//   channel | direction | transfer when          | payload
//   req     | in        | req_valid & !req_stall | req_type, req_row, req_col, req_cell_in
//   rsp     | out       | rsp_valid & !rsp_stall | rsp_cell_out, rsp_req_done
//
// Write and read: the row is read from the grid RAM, then modified and written
// back or its bit picked, and the response is registered.
// Advance: one row read per cycle from the grid RAM; the new row is built from a
// three-row window and written back in place one row behind, and the response is
// registered as the last row is written.
// Request kind 3: response in the cycle after its transfer.
// After reset a clearing pass writes every row to zero; req_stall is high meanwhile.
// One request is in flight at a time; a held response stalls the next request only
// if it is still not taken.
module life_generation_engine #(
   parameter int ROWS = lge_pkg::ROWS_DEF,
   parameter int COLS = lge_pkg::COLS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lge_pkg::kind_type        req_type,
   input  logic [lge_pkg::ROW_W-1:0] req_row,
   input  logic [lge_pkg::COL_W-1:0] req_col,
   input  logic                     req_cell_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_cell_out,
   output lge_pkg::kind_type        rsp_req_done
);

   localparam int AW = $clog2(ROWS);
   localparam int CW = $clog2(ROWS + 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RMW   = 2'd2;
   localparam logic [1:0] ST_ADV   = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             rd_cnt_ff, rd_cnt_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [COLS-1:0]           up_ff, up_in;
   logic [COLS-1:0]           mid_ff, mid_in;
   lge_pkg::kind_type         kind_ff, kind_in;
   logic [lge_pkg::ROW_W-1:0] row_ff, row_in;
   logic [lge_pkg::COL_W-1:0] col_ff, col_in;
   logic                      cell_ff, cell_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_cell_ff, rsp_cell_in;
   lge_pkg::kind_type         rsp_done_ff, rsp_done_in;

   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr;
   logic [COLS-1:0]           ram_wr_data;
   logic                      ram_rd_en;
   logic [AW-1:0]             ram_rd_addr;
   logic [COLS-1:0]           ram_q;

   logic                      req_accept;
   logic                      row_ok;
   logic                      rd_bit;
   logic                      adv_step;
   logic [CW-1:0]             cnt_m1;
   logic [COLS-1:0]           col_hit;
   logic [COLS-1:0]           mod_row;
   logic [COLS-1:0]           dn_row;
   logic [COLS-1:0]           next_row;
   logic [COLS+1:0]           up_pad, mid_pad, dn_pad;

   lge_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign row_ok = 32'(row_ff) < 32'(ROWS);
   assign rd_bit = |(ram_q & col_hit);

   // Row below the one being built; zero once past the bottom edge.
   assign dn_row   = rd_vld_ff ? ram_q : '0;
   assign adv_step = rd_vld_ff || (rd_cnt_ff == CW'(ROWS));
   assign cnt_m1   = cnt_ff - 1'b1;

   // Zero padding at both ends stands for the dead cells beyond the side edges.
   assign up_pad  = {1'b0, up_ff, 1'b0};
   assign mid_pad = {1'b0, mid_ff, 1'b0};
   assign dn_pad  = {1'b0, dn_row, 1'b0};

   for (genvar g = 0; g < COLS; g++) begin : g_col
      logic [3:0] nbr;

      assign nbr = 4'(up_pad[g])  + 4'(up_pad[g+1])  + 4'(up_pad[g+2])
                 + 4'(mid_pad[g])                     + 4'(mid_pad[g+2])
                 + 4'(dn_pad[g])  + 4'(dn_pad[g+1])  + 4'(dn_pad[g+2]);
      assign next_row[g] = (nbr == 4'd3) || (mid_ff[g] && (nbr == 4'd2));

      assign col_hit[g] = 32'(col_ff) == g;
      assign mod_row[g] = col_hit[g] ? cell_ff : ram_q[g];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_vld_in    = 1'b0;
      up_in        = up_ff;
      mid_in       = mid_ff;
      kind_in      = kind_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      rsp_done_in  = rsp_done_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cnt_ff[AW-1:0];
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(req_row);

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (cnt_ff == CW'(ROWS - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               kind_in = req_type;
               row_in  = req_row;
               col_in  = req_col;
               cell_in = req_cell_in;
               if (req_type inside {lge_pkg::REQ_WRITE, lge_pkg::REQ_READ}) begin
                  ram_rd_en = 1'b1;
                  state_in  = ST_RMW;
               end else if (req_type == lge_pkg::REQ_ADVANCE) begin
                  state_in  = ST_ADV;
                  cnt_in    = '0;
                  rd_cnt_in = '0;
                  up_in     = '0;
                  mid_in    = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_cell_in  = 1'b0;
                  rsp_done_in  = req_type;
               end
            end
         end
         ST_RMW: begin
            ram_wr_en    = (kind_ff == lge_pkg::REQ_WRITE) && row_ok;
            ram_wr_addr  = AW'(row_ff);
            ram_wr_data  = mod_row;
            rsp_valid_in = 1'b1;
            rsp_cell_in  = (kind_ff == lge_pkg::REQ_READ) && row_ok && rd_bit;
            rsp_done_in  = kind_ff;
            state_in     = ST_IDLE;
         end
         ST_ADV: begin
            if (rd_cnt_ff != CW'(ROWS)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_cnt_ff[AW-1:0];
               rd_cnt_in   = rd_cnt_ff + 1'b1;
               rd_vld_in   = 1'b1;
            end
            // cnt_ff counts window shifts; the new row lands one row behind the read.
            if (adv_step) begin
               up_in  = mid_ff;
               mid_in = dn_row;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff != '0) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = cnt_m1[AW-1:0];
                  ram_wr_data = next_row;
               end
               if (cnt_ff == CW'(ROWS)) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_cell_in  = 1'b0;
                  rsp_done_in  = kind_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_cnt_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff       <= up_in;
      mid_ff      <= mid_in;
      kind_ff     <= kind_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      cell_ff     <= cell_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_ff;
   assign rsp_req_done = rsp_done_ff;

endmodule

>>> design/lge_chk.sv
// lge_chk: port-level checks on the life generation engine, bound to the top level.
// Depends on lge_pkg.
module lge_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lge_pkg::kind_type req_type,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_cell_out,
   input lge_pkg::kind_type rsp_req_done
);

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_out) && $stable(rsp_req_done))
      else $error("response changed while stalled");

   // Only a read can return a live cell.
   a_cell_read_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_req_done != lge_pkg::REQ_READ) |-> !rsp_cell_out)
      else $error("cell_out set on a non-read response");

   // A cell access or an advance keeps the request side closed in the next cycle.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type != lge_pkg::REQ_NOP) |=> req_stall)
      else $error("request taken while one is in flight");

   // Cell writes and reads answer with their kind, after the RAM read register and then the response register.
   a_cell_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
      && ((req_type == lge_pkg::REQ_WRITE) || (req_type == lge_pkg::REQ_READ))
      |=> ##1 rsp_valid && (rsp_req_done == $past(req_type, 2)))
      else $error("cell access response missing or wrong");

   // Reset leaves no response and starts the clearing pass.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("bad state after reset");

endmodule

bind life_generation_engine lge_chk u_lge_chk (.*);
